// ===== sv/snt_pkg.sv =====
`timescale 1ns / 1ps
package snt_pkg;

  localparam int MAX_BLOCKS  = 6;
  localparam int SHW         = 11;
  localparam int MAX_RESULTS = 64;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_FIND_ONE  = 2'd2,
    CMD_FIND_ALL  = 2'd3
  } cmd_t;

  localparam logic [2:0] CFG_MAX_DIFF = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_key;
    logic        status;
    logic        last;
  } out_t;

  typedef logic [MAX_BLOCKS-1:0][63:0] masks_t;

  typedef struct packed {
    logic [MAX_BLOCKS-1:0][63:0]    run;
    logic [MAX_BLOCKS-1:0][SHW-1:0] shift;
    logic [8:0]                     sw;
  } layout_t;

  localparam masks_t MASK_RST = {
    64'd1023, 64'd1047552, 64'd2146435072, 64'd4395899027456,
    64'd9002801208229888, 64'd18437736874454810624
  };

  function automatic logic [6:0] popcnt(input logic [63:0] v);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) c = c + 7'(v[i]);
    return c;
  endfunction

  function automatic logic [63:0] lowbits(input logic [6:0] n);
    logic [63:0] r;
    if (n >= 7'd64) r = '1;
    else r = (64'd1 << n[5:0]) - 64'd1;
    return r;
  endfunction

  // signed shift: positive moves up, negative moves down
  function automatic logic [63:0] shsg(input logic [63:0] v, input logic [SHW-1:0] s);
    logic [SHW-1:0] ns;
    logic [63:0]    r;
    ns = -s;
    if (!s[SHW-1] && s != '0) begin
      r = (s >= SHW'(64)) ? 64'd0 : (v << s[5:0]);
    end else begin
      r = (ns >= SHW'(64)) ? 64'd0 : (v >> ns[5:0]);
    end
    return r;
  endfunction

  function automatic logic [63:0] permute(input logic [63:0] h, input layout_t l);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) r = r | shsg(h & l.run[k], l.shift[k]);
    return r;
  endfunction

  function automatic logic [63:0] unpermute(input logic [63:0] h, input layout_t l);
    logic [63:0] r;
    logic [63:0] rev;
    r = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      rev = shsg(l.run[k], l.shift[k]);
      r   = r | shsg(h & rev, -l.shift[k]);
    end
    return r;
  endfunction

endpackage

// ===== sv/snt_store.sv =====
`timescale 1ns / 1ps
module snt_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/snt_layout.sv =====
`timescale 1ns / 1ps
module snt_layout import snt_pkg::*; #(
  parameter int BLOCKS   = 6,
  parameter int KEY_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  masks_t     masks,
  input  logic [2:0] max_diff,
  output layout_t    lay,
  output logic       done
);

  localparam logic [63:0] KMASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

  logic          active_r, active_nxt;
  logic          done_r, done_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [8:0]    total_r, total_nxt;
  layout_t       lay_r, lay_nxt;

  logic [63:0]   m, lsb, run;
  logic [6:0]    wid, tz;
  logic [8:0]    tot_new;

  always_comb begin
    m       = masks[k_r] & KMASK;
    lsb     = m & (~m + 64'd1);
    run     = m & ~(m + lsb);
    wid     = popcnt(run);
    tz      = popcnt(lsb - 64'd1);
    tot_new = total_r + 9'(wid);

    active_nxt = active_r;
    done_nxt   = 1'b0;
    k_nxt      = k_r;
    total_nxt  = total_r;
    lay_nxt    = lay_r;
    if (go) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
      total_nxt  = '0;
      lay_nxt    = '0;
    end else if (active_r) begin
      if (m != 64'd0) begin
        lay_nxt.run[k_r]   = run;
        lay_nxt.shift[k_r] = SHW'(KEY_BITS) - SHW'(tot_new) - SHW'(tz);
        total_nxt          = tot_new;
        if ({1'b0, k_r} + {1'b0, max_diff} < 4'(BLOCKS)) begin
          lay_nxt.sw = lay_r.sw + 9'(wid);
        end
      end
      if (k_r == 3'(BLOCKS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      k_r      <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      k_r      <= k_nxt;
    end
    total_r <= total_nxt;
    lay_r   <= lay_nxt;
  end

  assign lay  = lay_r;
  assign done = done_r;

endmodule

// ===== sv/simhash_near_duplicate_table.sv =====
`timescale 1ns / 1ps
// Insert and remove walk the layout, permute the key, scan every slot, then strobe one result.
//   A find does the same layout and permute setup, then one full scan pass per
//   reported match plus a final empty pass (skipped once the item is satisfied), then flushes.
// Throughput: one item at a time; busy drops in the cycle the final result is strobed.
// Reset: synchronous, active low; a pass over every slot then clears the valid bits, busy high.
//   Results are single-cycle strobes and the receiver cannot stall them.
module simhash_near_duplicate_table import snt_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int BLOCKS   = 6,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  output logic        out_valid,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [63:0] KMASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LAYOUT = 7'b0000100,
    S_PERM   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DONE   = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;

  // configuration registers
  masks_t        mask_r;
  logic [2:0]    md_r;

  // latched item and derived search bounds
  logic [1:0]    cmd_r, cmd_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [63:0]   pk_r, pk_nxt, lo_r, lo_nxt, hi_r, hi_nxt;

  // scan control
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;

  // per-pass findings
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_slot_r, hit_slot_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_slot_r, free_slot_nxt;
  logic          best_ok_r, best_ok_nxt;
  logic [63:0]   best_r, best_nxt;

  // find sequencing across passes
  logic          have_prev_r, have_prev_nxt;
  logic [63:0]   prev_r, prev_nxt;
  logic          pend_r, pend_nxt;
  logic [63:0]   pend_key_r, pend_key_nxt;
  logic [6:0]    nres_r, nres_nxt;

  // output register
  logic          ov_r, ov_nxt;
  out_t          out_r, out_nxt;

  // memory and layout hookups
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [KEY_BITS:0] mem_wdata, mem_rdata;
  logic          lay_go, lay_done;
  layout_t       lay;

  logic [63:0]   rkey, sm;
  logic          rvld, in_range, near;
  logic [6:0]    sw_c;

  snt_store #(.DEPTH(CAPACITY), .WIDTH(KEY_BITS + 1)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  snt_layout #(.BLOCKS(BLOCKS), .KEY_BITS(KEY_BITS)) u_layout (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (lay_go),
    .masks    (mask_r),
    .max_diff (md_r),
    .lay      (lay),
    .done     (lay_done)
  );

  // configuration writes, accepted at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RST;
      md_r   <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index < CFG_MAX_DIFF) mask_r[cfg_index] <= cfg_wdata;
      else if (cfg_index == CFG_MAX_DIFF) md_r <= cfg_wdata[2:0];
    end
  end

  // evaluate the entry read back from memory
  always_comb begin
    rkey     = 64'(mem_rdata[KEY_BITS-1:0]);
    rvld     = mem_rdata[KEY_BITS];
    in_range = (rkey >= lo_r) && (rkey <= hi_r) && (!have_prev_r || rkey > prev_r);
    near     = popcnt(rkey ^ pk_r) <= {4'd0, md_r};
    sw_c     = (lay.sw > 9'(KEY_BITS)) ? 7'(KEY_BITS) : 7'(lay.sw);
    sm       = (lowbits(sw_c) << (7'(KEY_BITS) - sw_c)) & KMASK;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pk_nxt        = pk_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    best_ok_nxt   = best_ok_r;
    best_nxt      = best_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    pend_key_nxt  = pend_key_r;
    nres_nxt      = nres_r;
    ov_nxt        = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = '0;
    mem_raddr     = cnt_r[AW-1:0];
    lay_go        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // sweep the valid bits after reset
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = in_item.command;
          key_nxt       = in_item.key & KMASK;
          lay_go        = 1'b1;
          have_prev_nxt = 1'b0;
          pend_nxt      = 1'b0;
          nres_nxt      = '0;
          state_nxt     = S_LAYOUT;
        end
      end
      S_LAYOUT: begin
        if (lay_done) state_nxt = S_PERM;
      end
      S_PERM: begin
        pk_nxt      = permute(key_r, lay) & KMASK;
        lo_nxt      = pk_nxt & sm;
        hi_nxt      = (pk_nxt | ~sm) & KMASK;
        cnt_nxt     = '0;
        hit_nxt     = 1'b0;
        free_nxt    = 1'b0;
        best_ok_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        // issue one read a cycle, evaluate the returned data on the following cycle
        if (cnt_r != CW'(CAPACITY)) begin
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end
        if (rv_r) begin
          if (rvld && rkey == pk_r) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = ridx_r;
          end
          if (!rvld && !free_r) begin
            free_nxt      = 1'b1;
            free_slot_nxt = ridx_r;
          end
          if (rvld && in_range && near && (!best_ok_r || rkey < best_r)) begin
            best_ok_nxt = 1'b1;
            best_nxt    = rkey;
          end
        end
        if (cnt_r == CW'(CAPACITY)) state_nxt = S_DONE;
      end
      S_DONE: begin
        case (cmd_r)
          CMD_INSERT: begin
            ov_nxt  = 1'b1;
            out_nxt = '{found: 1'b0, match_key: 64'd0, status: 1'b0, last: 1'b1};
            if (!hit_r) begin
              if (free_r) begin
                mem_we    = 1'b1;
                mem_waddr = free_slot_r;
                mem_wdata = {1'b1, pk_r[KEY_BITS-1:0]};
              end else begin
                out_nxt.status = 1'b1;
              end
            end
            state_nxt = S_IDLE;
          end
          CMD_REMOVE: begin
            ov_nxt  = 1'b1;
            out_nxt = '{found: 1'b0, match_key: 64'd0, status: 1'b0, last: 1'b1};
            if (hit_r) begin
              mem_we    = 1'b1;
              mem_waddr = hit_slot_r;
            end
            state_nxt = S_IDLE;
          end
          default: begin
            if (best_ok_r) begin
              // hold the newest match back until we know whether it is the last
              if (pend_r) begin
                ov_nxt  = 1'b1;
                out_nxt = '{found: 1'b1, match_key: pend_key_r, status: 1'b0, last: 1'b0};
              end
              pend_nxt      = 1'b1;
              pend_key_nxt  = unpermute(best_r, lay) & KMASK;
              prev_nxt      = best_r;
              have_prev_nxt = 1'b1;
              nres_nxt      = nres_r + 7'd1;
              if (cmd_r == CMD_FIND_ONE || nres_nxt == 7'(MAX_RESULTS)) begin
                state_nxt = S_FLUSH;
              end else begin
                cnt_nxt     = '0;
                best_ok_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end else begin
              state_nxt = S_FLUSH;
            end
          end
        endcase
      end
      S_FLUSH: begin
        ov_nxt = 1'b1;
        if (pend_r) begin
          out_nxt = '{found: 1'b1, match_key: pend_key_r, status: 1'b0, last: 1'b1};
        end else begin
          out_nxt = '{found: 1'b0, match_key: 64'd0, status: 1'b0, last: 1'b1};
        end
        pend_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      nres_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      nres_r  <= nres_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    pk_r        <= pk_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ridx_r      <= ridx_nxt;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_r      <= free_nxt;
    free_slot_r <= free_slot_nxt;
    best_ok_r   <= best_ok_nxt;
    best_r      <= best_nxt;
    have_prev_r <= have_prev_nxt;
    prev_r      <= prev_nxt;
    pend_key_r  <= pend_key_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

// ===== sv/snt_checker.sv =====
`timescale 1ns / 1ps
module snt_checker import snt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_item
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("reset must leave the block busy and silent");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.last && out_item.match_key == 64'd0)
    else $error("miss result must be last with zero key");

  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> !out_item.found && out_item.last)
    else $error("table-full status on a match or non-final result");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> busy)
    else $error("block idled before the final result");

endmodule

bind simhash_near_duplicate_table snt_checker u_snt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb import snt_pkg::*; ();

  localparam int NSLOT      = 64;
  localparam int NBLK       = 6;
  localparam int SETTLE_CYC = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_item = '0;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  simhash_near_duplicate_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: configuration, key memory and derived layout.
  logic [63:0] shadow_mask [NBLK];
  logic [2:0]  shadow_diff;
  logic [63:0] shadow_keys [NSLOT];
  logic        shadow_used [NSLOT];
  logic [63:0] lay_run [NBLK];
  int          lay_shift [NBLK];
  int          lay_width [NBLK];

  out_t        pending_results[$];
  int          error_count = 0;
  int          idle_pct = 0;
  logic [63:0] base_keys [16];

  function automatic logic [63:0] ones_below(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Positive amounts move bits up, negative move them down; 64 or more clears.
  function automatic logic [63:0] move_bits(logic [63:0] v, int s);
    if (s > 0) return (s >= 64) ? 64'd0 : (v << s);
    return (-s >= 64) ? 64'd0 : (v >> (-s));
  endfunction

  function automatic void derive_layout();
    int total;
    int lo;
    int hi;
    logic [63:0] m;
    total = 0;
    for (int k = 0; k < NBLK; k++) begin
      m = shadow_mask[k];
      lay_run[k] = '0; lay_width[k] = 0; lay_shift[k] = 0;
      if (m != 0) begin
        lo = 0;
        while (!m[lo]) lo++;
        hi = lo;
        while (hi < 64 && m[hi]) hi++;
        lay_width[k] = hi - lo;
        lay_run[k]   = ones_below(hi - lo) << lo;
        total       += hi - lo;
        lay_shift[k] = 64 - total - lo;
      end
    end
  endfunction

  function automatic logic [63:0] scramble(logic [63:0] h);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NBLK; k++) r |= move_bits(h & lay_run[k], lay_shift[k]);
    return r;
  endfunction

  function automatic logic [63:0] unscramble(logic [63:0] h);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NBLK; k++)
      r |= move_bits(h & move_bits(lay_run[k], lay_shift[k]), -lay_shift[k]);
    return r;
  endfunction

  function automatic logic [63:0] probe_mask();
    int w;
    w = 0;
    for (int k = 0; k + shadow_diff < NBLK; k++) w += lay_width[k];
    if (w > 64) w = 64;
    return move_bits(ones_below(w), 64 - w);
  endfunction

  function automatic int bit_count(logic [63:0] v);
    int c;
    c = 0;
    for (int i = 0; i < 64; i++) c += v[i];
    return c;
  endfunction

  function automatic int slot_of(logic [63:0] pk);
    for (int s = 0; s < NSLOT; s++)
      if (shadow_used[s] && shadow_keys[s] == pk) return s;
    return -1;
  endfunction

  function automatic void push_result(logic f, logic [63:0] m, logic st, logic l);
    out_t r;
    r.found = f; r.match_key = m; r.status = st; r.last = l;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Apply one accepted item to the shadow table and queue what it yields.
  function automatic void predict_item(in_t it);
    logic [63:0] pk;
    logic [63:0] sm;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] prev;
    logic        have_prev;
    int          best;
    int          n;
    int          s;
    derive_layout();
    pk = scramble(it.key);
    case (cmd_t'(it.command))
      CMD_INSERT: begin
        logic st;
        st = 1'b0;
        if (slot_of(pk) < 0) begin
          s = 0;
          while (s < NSLOT && shadow_used[s]) s++;
          if (s < NSLOT) begin
            shadow_keys[s] = pk; shadow_used[s] = 1'b1;
          end else st = 1'b1;
        end
        push_result(1'b0, '0, st, 1'b1);
      end
      CMD_REMOVE: begin
        s = slot_of(pk);
        if (s >= 0) shadow_used[s] = 1'b0;
        push_result(1'b0, '0, 1'b0, 1'b1);
      end
      default: begin
        sm = probe_mask();
        lo = pk & sm;
        hi = pk | ~sm;
        prev = '0; have_prev = 1'b0; n = 0;
        forever begin
          best = -1;
          for (int t = 0; t < NSLOT; t++) begin
            if (!shadow_used[t] || shadow_keys[t] < lo || shadow_keys[t] > hi) continue;
            if (have_prev && shadow_keys[t] <= prev) continue;
            if (best < 0 || shadow_keys[t] < shadow_keys[best]) best = t;
          end
          if (best < 0) break;
          prev = shadow_keys[best]; have_prev = 1'b1;
          if (bit_count(prev ^ pk) <= shadow_diff) begin
            push_result(1'b1, unscramble(prev), 1'b0, 1'b0);
            n++;
            if (it.command == CMD_FIND_ONE || n >= MAX_RESULTS) break;
          end
        end
        if (n == 0) push_result(1'b0, '0, 1'b0, 1'b1);
        else pending_results[pending_results.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Every strobed result must match the oldest expectation; the receiver cannot stall.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_item.match_key, '0);
      end else begin
        out_t w;
        w = pending_results.pop_front();
        if (out_item.found !== w.found)
          report_mismatch("found", 64'(out_item.found), 64'(w.found));
        if (out_item.match_key !== w.match_key)
          report_mismatch("match_key", out_item.match_key, w.match_key);
        if (out_item.status !== w.status)
          report_mismatch("status", 64'(out_item.status), 64'(w.status));
        if (out_item.last !== w.last)
          report_mismatch("last", 64'(out_item.last), 64'(w.last));
      end
    end
  end

  // Hold start until the block takes the item, then sometimes drop start and idle at random.
  task automatic send_item(cmd_t c, logic [63:0] k);
    in_t it;
    it.command = c; it.key = k;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected item has come and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only called while idle.
  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MAX_DIFF) shadow_diff = v[2:0];
    else if (idx < CFG_MAX_DIFF) shadow_mask[idx] = v;
  endtask

  task automatic load_default_layout(logic [2:0] diff);
    for (int k = 0; k < NBLK; k++) write_reg(3'(k), MASK_RST[k]);
    write_reg(CFG_MAX_DIFF, {61'd0, diff});
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Flip up to n random bits of a key.
  function automatic logic [63:0] nudge(logic [63:0] k, int n);
    for (int i = 0; i < n; i++) k[$urandom_range(63)] ^= 1'b1;
    return k;
  endfunction

  function automatic logic [63:0] rand_run();
    int lo;
    int w;
    lo = $urandom_range(63);
    w  = $urandom_range(1, 64 - lo);
    return ones_below(w) << lo;
  endfunction

  task automatic test_reset();
    for (int k = 0; k < NBLK; k++) shadow_mask[k] = MASK_RST[k];
    shadow_diff = 3'd3;
    for (int s = 0; s < NSLOT; s++) begin
      shadow_keys[s] = '0; shadow_used[s] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Ride out the clearing pass after reset.
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Field extremes, each command, duplicates, absent removes, exact and near hits.
  task automatic test_directed();
    logic [63:0] a;
    a = 64'h0123_4567_89ab_cdef;
    send_item(CMD_FIND_ONE, '0);
    send_item(CMD_FIND_ALL, '1);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, '1);
    send_item(CMD_INSERT, '1);
    send_item(CMD_FIND_ONE, '0);
    send_item(CMD_FIND_ALL, 64'h7);
    send_item(CMD_FIND_ONE, '1);
    send_item(CMD_REMOVE, 64'h5555_5555_5555_5555);
    send_item(CMD_INSERT, a);
    send_item(CMD_INSERT, a ^ 64'h1);
    send_item(CMD_INSERT, a ^ 64'h300);
    send_item(CMD_INSERT, a ^ 64'h8000_0000_0000_0001);
    send_item(CMD_FIND_ALL, a);
    send_item(CMD_FIND_ONE, a ^ 64'h2);
    send_item(CMD_FIND_ALL, a ^ 64'hf);
    send_item(CMD_REMOVE, a);
    send_item(CMD_FIND_ALL, a);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_REMOVE, '1);
    wait_idle();
  endtask

  // Fill every slot, get one insert refused, then empty the table again.
  task automatic test_table_full();
    logic [63:0] k0;
    k0 = rand_key();
    for (int i = 0; i <= NSLOT; i++) send_item(CMD_INSERT, k0 ^ 64'(i));
    send_item(CMD_INSERT, k0);
    wait_idle();
    // Widest search reports many matches at once.
    write_reg(CFG_MAX_DIFF, 64'd6);
    send_item(CMD_FIND_ALL, k0);
    send_item(CMD_FIND_ONE, k0 ^ 64'h3f);
    for (int i = 0; i < NSLOT; i++) send_item(CMD_REMOVE, k0 ^ 64'(i));
    wait_idle();
  endtask

  // Odd masks: zero, scattered bits, overlapping and oversized runs; change under stored keys.
  task automatic test_mask_corners();
    logic [63:0] k0;
    k0 = rand_key();
    write_reg(3'd0, '0);
    write_reg(3'd1, 64'hf0f0_0000_0000_0000);
    write_reg(3'd2, 64'h0000_ffff_ffff_0000);
    write_reg(3'd3, 64'h0000_00ff_ff00_0000);
    write_reg(3'd4, '1);
    write_reg(3'd5, 64'h8000_0000_0000_0000);
    write_reg(CFG_MAX_DIFF, 64'd0);
    for (int i = 0; i < 6; i++) send_item(CMD_INSERT, nudge(k0, i));
    send_item(CMD_FIND_ALL, k0);
    send_item(CMD_FIND_ONE, nudge(k0, 1));
    wait_idle();
    load_default_layout(3'd2);
    send_item(CMD_FIND_ALL, k0);
    send_item(CMD_REMOVE, k0);
    send_item(CMD_FIND_ALL, '0);
    wait_idle();
    load_default_layout(3'd6);
    send_item(CMD_FIND_ALL, k0);
    for (int i = 0; i < 6; i++) send_item(CMD_REMOVE, nudge(k0, i));
    wait_idle();
  endtask

  task automatic pick_layout();
    int kind;
    kind = $urandom_range(3);
    for (int k = 0; k < NBLK; k++) begin
      case (kind)
        0: write_reg(3'(k), MASK_RST[k]);
        1: write_reg(3'(k), rand_run());
        2: write_reg(3'(k), ($urandom_range(3) == 0) ? rand_key() : MASK_RST[k]);
        default: write_reg(3'(k), ($urandom_range(4) == 0) ? 64'd0 : MASK_RST[k]);
      endcase
    end
    write_reg(CFG_MAX_DIFF, 64'($urandom_range(6)));
  endtask

  // Mostly inserts, removes and near-miss finds around a few base keys, with some noise.
  task automatic test_random_phase(int pct, int items, bit pause);
    int r;
    logic [63:0] k;
    idle_pct = pct;
    for (int i = 0; i < 16; i++) base_keys[i] = rand_key();
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 49) begin
        wait_idle();
        pick_layout();
      end
      if (pause && i % 37 == 36) wait_idle();
      r = $urandom_range(99);
      k = nudge(base_keys[$urandom_range(15)], $urandom_range(5));
      if (r < 8) k = rand_key();
      if (r < 35) send_item(CMD_INSERT, k);
      else if (r < 55) send_item(CMD_REMOVE, k);
      else if (r < 75) send_item(CMD_FIND_ONE, k);
      else send_item(CMD_FIND_ALL, k);
    end
    wait_idle();
  endtask

  initial begin
    test_reset();
    test_directed();
    test_table_full();
    test_mask_corners();
    test_random_phase(20, 110, 1'b1);
    test_random_phase(48, 110, 1'b0);
    load_default_layout(3'd3);
    test_random_phase(0, 110, 1'b0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule
